[src/frc_pkg.sv]
// ----------------------------------------------------------------------------
// frc_pkg
// Types, constants and single-step arithmetic helpers for the pipelined
// unpolarized Fresnel reflectance unit.
// ----------------------------------------------------------------------------
package frc_pkg;

  localparam int FRAC_BITS = 24;
  localparam int ONE_W     = FRAC_BITS + 1;
  localparam int IDX_W     = FRAC_BITS + 2;
  localparam int RAD_W     = 2 * ONE_W;
  localparam int ROOT_W    = ONE_W;
  localparam int SQREM_W   = FRAC_BITS + 3;
  localparam int DEN_W     = IDX_W + 1;
  localparam int Q_W       = FRAC_BITS;
  localparam int PROD_W    = 2 * ONE_W + 1;
  localparam int RND_W     = PROD_W - FRAC_BITS;
  localparam int NS_W      = IDX_W + ONE_W;
  localparam int TERM_W    = ONE_W + 1;
  localparam int PIPE_LAT  = 4 * FRAC_BITS + 14;

  localparam logic [ONE_W-1:0]  ONE    = ONE_W'(1) << FRAC_BITS;
  localparam logic [RAD_W-1:0]  ONE_SQ = RAD_W'(1) << (2 * FRAC_BITS);
  localparam logic [PROD_W-1:0] HALF   = PROD_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    CASE_MATCHED    = 3'd0,
    CASE_NORMAL     = 3'd1,
    CASE_GRAZING    = 3'd2,
    CASE_TIR        = 3'd3,
    CASE_GENERAL    = 3'd4,
    CASE_ZERO_INDEX = 3'd5
  } case_code_t;

  typedef enum logic [0:0] {
    REG_NORMAL_TOL  = 1'b0,
    REG_GRAZING_TOL = 1'b1
  } cfg_index_t;

  typedef struct packed {
    case_code_t         code;
    logic               fin;
    logic               sat1;
    logic               sat2;
    logic [ONE_W-1:0]   refl;
    logic [ONE_W-1:0]   cost;
    logic [ONE_W-1:0]   c;
    logic [ONE_W-1:0]   s;
    logic [ONE_W-1:0]   st;
    logic [IDX_W-1:0]   ni;
    logic [IDX_W-1:0]   nt;
  } item_t;

  typedef struct packed {
    logic [RAD_W-1:0]   x;
    logic [SQREM_W-1:0] rem;
    logic [ROOT_W-1:0]  root;
  } sqrt_t;

  typedef struct packed {
    logic [DEN_W-1:0]   den;
    logic [DEN_W-1:0]   rem;
    logic [Q_W-1:0]     lo;
    logic [Q_W-1:0]     q;
  } div_t;

  // one root bit per call
  function automatic sqrt_t sqrt_step(sqrt_t a);
    sqrt_t                r;
    logic [SQREM_W+1:0]   acc;
    logic [SQREM_W+1:0]   trial;
    logic [SQREM_W+1:0]   diff;
    acc   = {a.rem, a.x[RAD_W-1 -: 2]};
    trial = {{(SQREM_W - ROOT_W){1'b0}}, a.root, 2'b01};
    diff  = acc - trial;
    r.x   = a.x << 2;
    if (acc >= trial) begin
      r.rem  = diff[SQREM_W-1:0];
      r.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = acc[SQREM_W-1:0];
      r.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit per call, remainder stays below the divisor
  function automatic div_t div_step(div_t a);
    div_t             r;
    logic [DEN_W:0]   acc;
    logic [DEN_W:0]   diff;
    acc   = {a.rem, a.lo[Q_W-1]};
    diff  = acc - {1'b0, a.den};
    r.den = a.den;
    r.lo  = a.lo << 1;
    if (acc >= {1'b0, a.den}) begin
      r.rem = diff[DEN_W-1:0];
      r.q   = {a.q[Q_W-2:0], 1'b1};
    end else begin
      r.rem = acc[DEN_W-1:0];
      r.q   = {a.q[Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // round half up back to FRAC_BITS fraction bits
  function automatic logic [RND_W-1:0] rnd(logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + {1'b0, HALF};
    return t[PROD_W-1:FRAC_BITS];
  endfunction

endpackage

[src/fresnel_reflectance_unit.sv]
// ----------------------------------------------------------------------------
// fresnel_reflectance_unit
// Unpolarized Fresnel reflectance and transmission cosine at a boundary.
// ----------------------------------------------------------------------------
// One item is taken in every clock cycle (busy stays low) and its result
// appears on reflectance, cos_transmission and case_code with done high for
// one cycle. The path runs through four bit-per-stage units in series: the
// sine root, the Snell division, the transmission-cosine root and the two
// reflectance quotient divisions. Results cannot be held off. Tolerance
// registers are written through cfg_valid/cfg_index/cfg_data; the user must
// write them only while no item is in flight, which the block itself does
// not enforce. cfg_ready is always high.
module fresnel_reflectance_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [frc_pkg::IDX_W-1:0]   index_incident,
  input  logic [frc_pkg::IDX_W-1:0]   index_transmit,
  input  logic [frc_pkg::ONE_W-1:0]   cos_incidence,
  output logic                        done,
  output logic [frc_pkg::ONE_W-1:0]   reflectance,
  output logic [frc_pkg::ONE_W-1:0]   cos_transmission,
  output frc_pkg::case_code_t         case_code,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  frc_pkg::cfg_index_t         cfg_index,
  input  logic [frc_pkg::ONE_W-1:0]   cfg_data
);
  import frc_pkg::*;

  logic [ONE_W-1:0] normal_tol;
  logic [ONE_W-1:0] grazing_tol;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_tol  <= '0;
      grazing_tol <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NORMAL_TOL:  normal_tol  <= cfg_data;
        REG_GRAZING_TOL: grazing_tol <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic             s0_vld;
  logic [IDX_W-1:0] s0_ni;
  logic [IDX_W-1:0] s0_nt;
  logic [ONE_W-1:0] s0_c;

  always_ff @(posedge clk) begin
    if (rst) s0_vld <= 1'b0;
    else     s0_vld <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s0_ni <= index_incident;
    s0_nt <= index_transmit;
    s0_c  <= cos_incidence;
  end

  // classify, sine radicand, normal-incidence division setup
  logic             a_vld [0:FRAC_BITS+1];
  item_t            a_it  [0:FRAC_BITS+1];
  sqrt_t            a_sq  [0:FRAC_BITS+1];
  div_t             a_dv  [0:FRAC_BITS+1];

  item_t            s1_it;
  sqrt_t            s1_sq;
  div_t             s1_dv;
  logic [ONE_W-1:0] c_sat;
  logic [RAD_W-1:0] csq;
  logic [IDX_W-1:0] ndiff;

  always_comb begin
    c_sat = (s0_c > ONE) ? ONE : s0_c;
    csq   = {{ONE_W{1'b0}}, c_sat} * {{ONE_W{1'b0}}, c_sat};
    ndiff = (s0_nt >= s0_ni) ? (s0_nt - s0_ni) : (s0_ni - s0_nt);
    s1_it = '0;
    s1_it.ni = s0_ni;
    s1_it.nt = s0_nt;
    s1_it.c  = c_sat;
    if (s0_ni == '0 || s0_nt == '0) begin
      s1_it.code = CASE_ZERO_INDEX;
      s1_it.fin  = 1'b1;
      s1_it.refl = ONE;
    end else if (s0_ni == s0_nt) begin
      s1_it.code = CASE_MATCHED;
      s1_it.fin  = 1'b1;
      s1_it.cost = c_sat;
    end else if (ONE - c_sat <= normal_tol) begin
      s1_it.code = CASE_NORMAL;
      s1_it.cost = c_sat;
    end else if (c_sat < grazing_tol) begin
      s1_it.code = CASE_GRAZING;
      s1_it.fin  = 1'b1;
      s1_it.refl = ONE;
    end else begin
      s1_it.code = CASE_GENERAL;
    end
    s1_sq.x    = ONE_SQ - csq;
    s1_sq.rem  = '0;
    s1_sq.root = '0;
    s1_dv.den  = {1'b0, s0_ni} + {1'b0, s0_nt};
    s1_dv.rem  = {1'b0, ndiff};
    s1_dv.lo   = '0;
    s1_dv.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) a_vld[0] <= 1'b0;
    else     a_vld[0] <= s0_vld;
  end

  always_ff @(posedge clk) begin
    a_it[0] <= s1_it;
    a_sq[0] <= s1_sq;
    a_dv[0] <= s1_dv;
  end

  // sine root, normal-incidence quotient alongside
  for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_a
    always_ff @(posedge clk) begin
      if (rst) a_vld[j+1] <= 1'b0;
      else     a_vld[j+1] <= a_vld[j];
    end
    always_ff @(posedge clk) begin
      a_it[j+1] <= a_it[j];
      a_sq[j+1] <= sqrt_step(a_sq[j]);
    end
    if (j < FRAC_BITS) begin : g_dv
      always_ff @(posedge clk) a_dv[j+1] <= div_step(a_dv[j]);
    end else begin : g_hold
      always_ff @(posedge clk) a_dv[j+1] <= a_dv[j];
    end
  end

  // index times sine, normal quotient squared
  logic              b1_vld;
  item_t             b1_it;
  logic [NS_W-1:0]   b1_ns;
  logic [2*Q_W-1:0]  b1_rr;
  item_t             a_out;

  always_comb begin
    a_out   = a_it[FRAC_BITS+1];
    a_out.s = a_sq[FRAC_BITS+1].root;
  end

  always_ff @(posedge clk) begin
    if (rst) b1_vld <= 1'b0;
    else     b1_vld <= a_vld[FRAC_BITS+1];
  end

  always_ff @(posedge clk) begin
    b1_it   <= a_out;
    b1_ns   <= {{ONE_W{1'b0}}, a_it[FRAC_BITS+1].ni}
             * {{IDX_W{1'b0}}, a_sq[FRAC_BITS+1].root};
    b1_rr   <= {{Q_W{1'b0}}, a_dv[FRAC_BITS+1].q} * {{Q_W{1'b0}}, a_dv[FRAC_BITS+1].q};
  end

  // total internal reflection test, Snell division setup
  logic             c_vld [0:FRAC_BITS];
  item_t            c_it  [0:FRAC_BITS];
  div_t             c_dv  [0:FRAC_BITS];
  item_t            b2_it;
  div_t             b2_dv;
  logic [RND_W-1:0] rr_rnd;
  logic             tir;

  always_comb begin
    tir    = b1_ns >= {1'b0, b1_it.nt, {FRAC_BITS{1'b0}}};
    rr_rnd = rnd({{(PROD_W - 2*Q_W){1'b0}}, b1_rr});
    b2_it  = b1_it;
    if (b1_it.code == CASE_NORMAL) begin
      b2_it.fin  = 1'b1;
      b2_it.refl = rr_rnd[ONE_W-1:0];
    end else if (b1_it.code == CASE_GENERAL && tir) begin
      b2_it.code = CASE_TIR;
      b2_it.fin  = 1'b1;
      b2_it.refl = ONE;
      b2_it.cost = '0;
    end
    b2_dv.den = {1'b0, b1_it.nt};
    b2_dv.rem = b1_ns[NS_W-1:FRAC_BITS];
    b2_dv.lo  = b1_ns[FRAC_BITS-1:0];
    b2_dv.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) c_vld[0] <= 1'b0;
    else     c_vld[0] <= b1_vld;
  end

  always_ff @(posedge clk) begin
    c_it[0] <= b2_it;
    c_dv[0] <= b2_dv;
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_c
    always_ff @(posedge clk) begin
      if (rst) c_vld[j+1] <= 1'b0;
      else     c_vld[j+1] <= c_vld[j];
    end
    always_ff @(posedge clk) begin
      c_it[j+1] <= c_it[j];
      c_dv[j+1] <= div_step(c_dv[j]);
    end
  end

  // transmission sine squared, cosine radicand
  logic             e_vld [0:FRAC_BITS+1];
  item_t            e_it  [0:FRAC_BITS+1];
  sqrt_t            e_sq  [0:FRAC_BITS+1];
  logic [ONE_W-1:0] d_st;
  logic [RAD_W-1:0] d_stsq;
  item_t            d_it;

  assign d_st   = {1'b0, c_dv[FRAC_BITS].q};
  assign d_stsq = {{ONE_W{1'b0}}, d_st} * {{ONE_W{1'b0}}, d_st};

  always_comb begin
    d_it    = c_it[FRAC_BITS];
    d_it.st = d_st;
  end

  always_ff @(posedge clk) begin
    if (rst) e_vld[0] <= 1'b0;
    else     e_vld[0] <= c_vld[FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    e_it[0]      <= d_it;
    e_sq[0].x    <= ONE_SQ - d_stsq;
    e_sq[0].rem  <= '0;
    e_sq[0].root <= '0;
  end

  for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_e
    always_ff @(posedge clk) begin
      if (rst) e_vld[j+1] <= 1'b0;
      else     e_vld[j+1] <= e_vld[j];
    end
    always_ff @(posedge clk) begin
      e_it[j+1] <= e_it[j];
      e_sq[j+1] <= sqrt_step(e_sq[j]);
    end
  end

  // cross products
  logic             g1_vld;
  item_t            g1_it;
  logic [RAD_W-1:0] g1_sct;
  logic [RAD_W-1:0] g1_cst;
  logic [RAD_W-1:0] g1_cct;
  logic [RAD_W-1:0] g1_sst;
  item_t            g1_next;
  logic [ONE_W-1:0] g_ct;

  always_comb begin
    g_ct    = e_sq[FRAC_BITS+1].root;
    g1_next = e_it[FRAC_BITS+1];
    if (!g1_next.fin) g1_next.cost = g_ct;
  end

  always_ff @(posedge clk) begin
    if (rst) g1_vld <= 1'b0;
    else     g1_vld <= e_vld[FRAC_BITS+1];
  end

  always_ff @(posedge clk) begin
    g1_it  <= g1_next;
    g1_sct <= {{ONE_W{1'b0}}, g1_next.s} * {{ONE_W{1'b0}}, g_ct};
    g1_cst <= {{ONE_W{1'b0}}, g1_next.c} * {{ONE_W{1'b0}}, g1_next.st};
    g1_cct <= {{ONE_W{1'b0}}, g1_next.c} * {{ONE_W{1'b0}}, g_ct};
    g1_sst <= {{ONE_W{1'b0}}, g1_next.s} * {{ONE_W{1'b0}}, g1_next.st};
  end

  // rounded sums and differences
  logic              g2_vld;
  item_t             g2_it;
  logic [TERM_W-1:0] g2_sm;
  logic [TERM_W-1:0] g2_sp;
  logic [TERM_W-1:0] g2_cp;
  logic [TERM_W-1:0] g2_cm;
  logic [PROD_W-1:0] t_sm;
  logic [PROD_W-1:0] t_sp;
  logic [PROD_W-1:0] t_cp;
  logic [PROD_W-1:0] t_cm;
  logic [RND_W-1:0]  r_sm;
  logic [RND_W-1:0]  r_sp;
  logic [RND_W-1:0]  r_cp;
  logic [RND_W-1:0]  r_cm;

  always_comb begin
    t_sm = (g1_sct >= g1_cst) ? {1'b0, g1_sct - g1_cst} : {1'b0, g1_cst - g1_sct};
    t_sp = {1'b0, g1_sct} + {1'b0, g1_cst};
    t_cp = (g1_cct >= g1_sst) ? {1'b0, g1_cct - g1_sst} : {1'b0, g1_sst - g1_cct};
    t_cm = {1'b0, g1_cct} + {1'b0, g1_sst};
    r_sm = rnd(t_sm);
    r_sp = rnd(t_sp);
    r_cp = rnd(t_cp);
    r_cm = rnd(t_cm);
  end

  always_ff @(posedge clk) begin
    if (rst) g2_vld <= 1'b0;
    else     g2_vld <= g1_vld;
  end

  always_ff @(posedge clk) begin
    g2_it <= g1_it;
    g2_sm <= r_sm[TERM_W-1:0];
    g2_sp <= r_sp[TERM_W-1:0];
    g2_cp <= r_cp[TERM_W-1:0];
    g2_cm <= r_cm[TERM_W-1:0];
  end

  // zero denominators, quotient saturation, quotient division setup
  logic  h_vld [0:FRAC_BITS];
  item_t h_it  [0:FRAC_BITS];
  div_t  h_d1  [0:FRAC_BITS];
  div_t  h_d2  [0:FRAC_BITS];
  item_t g3_it;

  always_comb begin
    g3_it      = g2_it;
    g3_it.sat1 = g2_sm >= g2_sp;
    g3_it.sat2 = g2_cp >= g2_cm;
    if (!g2_it.fin && (g2_sp == '0 || g2_cm == '0)) begin
      g3_it.fin  = 1'b1;
      g3_it.refl = ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) h_vld[0] <= 1'b0;
    else     h_vld[0] <= g2_vld;
  end

  always_ff @(posedge clk) begin
    h_it[0]     <= g3_it;
    h_d1[0].den <= {1'b0, g2_sp};
    h_d1[0].rem <= {1'b0, g2_sm};
    h_d1[0].lo  <= '0;
    h_d1[0].q   <= '0;
    h_d2[0].den <= {1'b0, g2_cm};
    h_d2[0].rem <= {1'b0, g2_cp};
    h_d2[0].lo  <= '0;
    h_d2[0].q   <= '0;
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_h
    always_ff @(posedge clk) begin
      if (rst) h_vld[j+1] <= 1'b0;
      else     h_vld[j+1] <= h_vld[j];
    end
    always_ff @(posedge clk) begin
      h_it[j+1] <= h_it[j];
      h_d1[j+1] <= div_step(h_d1[j]);
      h_d2[j+1] <= div_step(h_d2[j]);
    end
  end

  // quotients squared
  logic             k1_vld;
  item_t            k1_it;
  logic [RAD_W-1:0] k1_q1sq;
  logic [RAD_W-1:0] k1_q2sq;
  logic [ONE_W-1:0] q1;
  logic [ONE_W-1:0] q2;

  assign q1 = h_it[FRAC_BITS].sat1 ? ONE : {1'b0, h_d1[FRAC_BITS].q};
  assign q2 = h_it[FRAC_BITS].sat2 ? ONE : {1'b0, h_d2[FRAC_BITS].q};

  always_ff @(posedge clk) begin
    if (rst) k1_vld <= 1'b0;
    else     k1_vld <= h_vld[FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    k1_it   <= h_it[FRAC_BITS];
    k1_q1sq <= {{ONE_W{1'b0}}, q1} * {{ONE_W{1'b0}}, q1};
    k1_q2sq <= {{ONE_W{1'b0}}, q2} * {{ONE_W{1'b0}}, q2};
  end

  // rounding of the squares
  logic             k2_vld;
  item_t            k2_it;
  logic [ONE_W-1:0] k2_a;
  logic [ONE_W-1:0] k2_q2r;
  logic [RND_W-1:0] r_a;
  logic [RND_W-1:0] r_q2;

  assign r_a  = rnd({1'b0, k1_q1sq});
  assign r_q2 = rnd({1'b0, k1_q2sq});

  always_ff @(posedge clk) begin
    if (rst) k2_vld <= 1'b0;
    else     k2_vld <= k1_vld;
  end

  always_ff @(posedge clk) begin
    k2_it  <= k1_it;
    k2_a   <= r_a[ONE_W-1:0];
    k2_q2r <= r_q2[ONE_W-1:0];
  end

  // p-term product
  logic             k3_vld;
  item_t            k3_it;
  logic [ONE_W-1:0] k3_a;
  logic [RAD_W-1:0] k3_ab;

  always_ff @(posedge clk) begin
    if (rst) k3_vld <= 1'b0;
    else     k3_vld <= k2_vld;
  end

  always_ff @(posedge clk) begin
    k3_it <= k2_it;
    k3_a  <= k2_a;
    k3_ab <= {{ONE_W{1'b0}}, k2_a} * {{ONE_W{1'b0}}, k2_q2r};
  end

  // mean, saturation, output register
  logic [RND_W-1:0]  r_b;
  logic [TERM_W-1:0] mean_sum;
  logic [ONE_W-1:0]  mean;
  logic [ONE_W-1:0]  refl_next;

  always_comb begin
    r_b       = rnd({1'b0, k3_ab});
    mean_sum  = {1'b0, k3_a} + r_b[TERM_W-1:0] + TERM_W'(1);
    mean      = mean_sum[TERM_W-1:1];
    refl_next = k3_it.fin ? k3_it.refl : ((mean > ONE) ? ONE : mean);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= k3_vld;
  end

  always_ff @(posedge clk) begin
    reflectance      <= refl_next;
    cos_transmission <= k3_it.cost;
    case_code        <= k3_it.code;
  end

endmodule

[src/frc_checker.sv]
// ----------------------------------------------------------------------------
// frc_checker
// Port-level checks on result timing and case-dependent result values.
// ----------------------------------------------------------------------------
module frc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [frc_pkg::ONE_W-1:0]   reflectance,
  input logic [frc_pkg::ONE_W-1:0]   cos_transmission,
  input frc_pkg::case_code_t         case_code
);
  import frc_pkg::*;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##PIPE_LAT done)
    else $error("item result missing at fixed latency");

  a_refl_range: assert property (@(posedge clk) disable iff (rst)
    done |-> reflectance <= ONE)
    else $error("reflectance above one");

  a_full_refl: assert property (@(posedge clk) disable iff (rst)
    done && (case_code == CASE_ZERO_INDEX || case_code == CASE_GRAZING ||
             case_code == CASE_TIR)
    |-> reflectance == ONE && cos_transmission == '0)
    else $error("full reflection case with wrong result");

  a_matched: assert property (@(posedge clk) disable iff (rst)
    done && case_code == CASE_MATCHED |-> reflectance == '0)
    else $error("matched indices with nonzero reflectance");

endmodule

bind fresnel_reflectance_unit frc_checker u_frc_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .done             (done),
  .reflectance      (reflectance),
  .cos_transmission (cos_transmission),
  .case_code        (case_code)
);
